>>> rtl/core/lwt53_pkg.sv
// shared constants, codes and types of the 5/3 lifting wavelet core
package lwt53_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 24;
   localparam int INDEX_BITS = 16;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS = 16;
   localparam int MIN_SEQ_LENGTH = 3;
   localparam int SEQ_LENGTH_RESET = 8;
   localparam int QUEUE_DEPTH = 8;
   localparam int RESULTS_MAX = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DIRECTION  = 8'd0,
      CSR_SEQ_LENGTH = 8'd1
   } csr_index_type;

   typedef enum logic {
      DIR_FORWARD = 1'b0,
      DIR_INVERSE = 1'b1
   } direction_type;

   typedef struct packed {
      logic                      valid;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CSR_DATA_BITS-1:0]  data;
   } csr_write_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] index;
      logic                  last;
   } rsp_tag_type;

   typedef struct packed {
      logic [1:0]        count;
      rsp_tag_type [2:0] tag;
   } push_type;

endpackage

>>> rtl/core/lwt53_req_if.sv
// sample input channel
interface lwt53_req_if #(parameter int SAMPLE_BITS = lwt53_pkg::SAMPLE_BITS_DEFAULT);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

>>> rtl/core/lwt53_rsp_if.sv
// result output channel
interface lwt53_rsp_if #(parameter int SAMPLE_BITS = lwt53_pkg::SAMPLE_BITS_DEFAULT);
   logic                                   valid;
   logic                                   ready;
   logic signed [SAMPLE_BITS-1:0]          value;
   logic [lwt53_pkg::INDEX_BITS-1:0]       index;
   logic                                   last;

   modport source (output valid, output value, output index, output last, input ready);
   modport sink (input valid, input value, input index, input last, output ready);
endinterface

>>> rtl/core/lwt53_csr_if.sv
// configuration write channel
interface lwt53_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [lwt53_pkg::CSR_INDEX_BITS-1:0] index;
   logic [lwt53_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/lifting_wavelet_53_1d_core.sv
// top level of the streaming 5/3 lifting wavelet core
// Takes one sample per clock cycle while req ready is high, and returns results in ascending
// index order with a last flag on the final one of each sequence. A sample is registered on
// acceptance and its predict/update arithmetic runs in the following cycle, which pushes zero
// to three results into an eight-entry result queue; the queue hands out one result per cycle
// while rsp ready is high. Since results average one per sample, the queue drains at the input
// rate; req ready drops only while the queue could not absorb a burst of three more results.
// Configuration writes are taken at any time but are meant for idle periods; each write to a
// mapped register restarts the sequence at index zero.
module lifting_wavelet_53_1d_core #(
   parameter int SAMPLE_BITS = lwt53_pkg::SAMPLE_BITS_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   lwt53_req_if.sink    req_ch,
   lwt53_rsp_if.source  rsp_ch,
   lwt53_csr_if.sink    csr_ch
);
   import lwt53_pkg::*;

   csr_write_type               csr_write;
   push_type                    push;
   logic [2:0][SAMPLE_BITS-1:0] push_value;
   logic                        space_ok;
   logic                        in_accept;
   logic [SAMPLE_BITS-1:0]      out_value;
   rsp_tag_type                 out_tag;

   assign csr_ch.ready = 1'b1;
   assign csr_write.valid = csr_ch.valid;
   assign csr_write.index = csr_ch.index;
   assign csr_write.data = csr_ch.data;

   assign req_ch.ready = space_ok;
   assign in_accept = req_ch.valid && space_ok;

   lwt53_datapath #(.SAMPLE_BITS(SAMPLE_BITS)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .in_accept  (in_accept),
      .in_sample  (req_ch.sample),
      .push       (push),
      .push_value (push_value)
   );

   lwt53_rsp_queue #(.SAMPLE_BITS(SAMPLE_BITS)) u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_value (push_value),
      .space_ok   (space_ok),
      .out_valid  (rsp_ch.valid),
      .out_ready  (rsp_ch.ready),
      .out_value  (out_value),
      .out_tag    (out_tag)
   );

   assign rsp_ch.value = out_value;
   assign rsp_ch.index = out_tag.index;
   assign rsp_ch.last = out_tag.last;

endmodule

>>> rtl/core/lwt53_datapath.sv
// input register, lifting state and predict/update arithmetic
module lwt53_datapath #(
   parameter int SAMPLE_BITS = lwt53_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lwt53_pkg::csr_write_type            csr_write,
   input  logic                                in_accept,
   input  logic signed [SAMPLE_BITS-1:0]       in_sample,
   output lwt53_pkg::push_type                 push,
   output logic [2:0][SAMPLE_BITS-1:0]         push_value
);
   import lwt53_pkg::*;

   localparam int WIDE = SAMPLE_BITS + 3;
   typedef logic signed [WIDE-1:0] wide_type;
   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   function automatic wide_type ext(input sample_type v);
      return WIDE'(v);
   endfunction

   function automatic sample_type sat(input wide_type v);
      sample_type r;
      if (&v[WIDE-1:SAMPLE_BITS-1] || ~|v[WIDE-1:SAMPLE_BITS-1]) begin
         r = v[SAMPLE_BITS-1:0];
      end else if (v[WIDE-1]) begin
         r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
      return r;
   endfunction

   direction_type         direction_ff, direction_in;
   logic [INDEX_BITS-1:0] seq_length_ff, seq_length_in;
   logic [INDEX_BITS-1:0] position_ff, position_in;
   sample_type            low_even_ff, low_even_in;
   sample_type            low_odd_ff, low_odd_in;
   sample_type            held_ff, held_in;
   sample_type            older_ff, older_in;
   logic                  stage_valid_ff;
   sample_type            stage_sample_ff;

   logic [INDEX_BITS-1:0] last_pos;
   logic                  lastp;
   sample_type            x;
   sample_type            fwd_d_even, fwd_dprev, fwd_s_even, fwd_tail_even;
   sample_type            fwd_d_odd, fwd_s_odd;
   sample_type            inv_e_first, inv_e_last, inv_o_last;
   sample_type            inv_e_odd, inv_o_odd, inv_tail_odd;

   assign x = stage_sample_ff;
   assign last_pos = (seq_length_ff < INDEX_BITS'(MIN_SEQ_LENGTH))
                     ? INDEX_BITS'(MIN_SEQ_LENGTH - 1) : seq_length_ff - INDEX_BITS'(1);
   assign lastp = (position_ff == last_pos);

   // forward predict and update
   assign fwd_d_even    = sat(ext(held_ff) - ((ext(older_ff) + ext(x)) >>> 1));
   assign fwd_dprev     = (position_ff == INDEX_BITS'(2)) ? fwd_d_even : low_odd_ff;
   assign fwd_s_even    = sat(ext(older_ff) + ((ext(fwd_dprev) + ext(fwd_d_even)) >>> 2));
   assign fwd_tail_even = sat(ext(x) + (ext(fwd_d_even) >>> 1));
   assign fwd_d_odd     = sat(ext(x) - ext(older_ff));
   assign fwd_s_odd     = sat(ext(older_ff) + ((ext(low_odd_ff) + ext(fwd_d_odd)) >>> 2));

   // inverse undo update, then undo predict
   assign inv_e_first  = sat(ext(held_ff) - ((ext(x) + ext(x)) >>> 2));
   assign inv_e_last   = sat(ext(x) - (ext(low_odd_ff) >>> 1));
   assign inv_o_last   = sat(ext(low_odd_ff) + ((ext(low_even_ff) + ext(inv_e_last)) >>> 1));
   assign inv_e_odd    = sat(ext(held_ff) - ((ext(low_odd_ff) + ext(x)) >>> 2));
   assign inv_o_odd    = sat(ext(low_odd_ff) + ((ext(low_even_ff) + ext(inv_e_odd)) >>> 1));
   assign inv_tail_odd = sat(ext(x) + ext(inv_e_odd));

   always_comb begin
      push = '0;
      push_value = '0;
      direction_in = direction_ff;
      seq_length_in = seq_length_ff;
      position_in = position_ff;
      low_even_in = low_even_ff;
      low_odd_in = low_odd_ff;
      held_in = held_ff;
      older_in = older_ff;
      push.tag[0].index = position_ff - INDEX_BITS'(2);
      push.tag[1].index = position_ff - INDEX_BITS'(1);
      push.tag[2].index = position_ff;
      if (stage_valid_ff) begin
         position_in = lastp ? '0 : position_ff + INDEX_BITS'(1);
         if (direction_ff == DIR_FORWARD) begin
            if (position_ff == '0) begin
               older_in = x;
            end else if (position_ff == INDEX_BITS'(1)) begin
               held_in = x;
            end else if (!position_ff[0]) begin
               push.count = lastp ? 2'd3 : 2'd2;
               push_value[0] = fwd_s_even;
               push_value[1] = fwd_d_even;
               push_value[2] = fwd_tail_even;
               push.tag[2].last = 1'b1;
               older_in = x;
               low_odd_in = fwd_d_even;
            end else if (lastp) begin
               push.count = 2'd2;
               push_value[0] = fwd_s_odd;
               push_value[1] = fwd_d_odd;
               push.tag[0].index = position_ff - INDEX_BITS'(1);
               push.tag[1].index = position_ff;
               push.tag[1].last = 1'b1;
            end else begin
               held_in = x;
            end
         end else begin
            if (position_ff == '0) begin
               held_in = x;
            end else if (position_ff == INDEX_BITS'(1)) begin
               push.count = 2'd1;
               push_value[0] = inv_e_first;
               push.tag[0].index = '0;
               low_even_in = inv_e_first;
               low_odd_in = x;
            end else if (!position_ff[0]) begin
               if (lastp) begin
                  push.count = 2'd2;
                  push_value[0] = inv_o_last;
                  push_value[1] = inv_e_last;
                  push.tag[0].index = position_ff - INDEX_BITS'(1);
                  push.tag[1].index = position_ff;
                  push.tag[1].last = 1'b1;
               end else begin
                  held_in = x;
               end
            end else begin
               push.count = lastp ? 2'd3 : 2'd2;
               push_value[0] = inv_o_odd;
               push_value[1] = inv_e_odd;
               push_value[2] = inv_tail_odd;
               push.tag[2].last = 1'b1;
               low_even_in = inv_e_odd;
               low_odd_in = x;
            end
         end
      end
      if (csr_write.valid) begin
         unique case (csr_write.index)
            CSR_DIRECTION: begin
               direction_in = direction_type'(csr_write.data[0]);
               position_in = '0;
            end
            CSR_SEQ_LENGTH: begin
               seq_length_in = csr_write.data[INDEX_BITS-1:0];
               position_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= DIR_FORWARD;
         seq_length_ff <= INDEX_BITS'(SEQ_LENGTH_RESET);
         position_ff <= '0;
         low_even_ff <= '0;
         low_odd_ff <= '0;
         held_ff <= '0;
         older_ff <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         direction_ff <= direction_in;
         seq_length_ff <= seq_length_in;
         position_ff <= position_in;
         low_even_ff <= low_even_in;
         low_odd_ff <= low_odd_in;
         held_ff <= held_in;
         older_ff <= older_in;
         stage_valid_ff <= in_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         stage_sample_ff <= in_sample;
      end
   end

   a_first_silent: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && (position_ff == '0) |-> push.count == 2'd0)
      else $error("results pushed for the first sample of a sequence");

   a_fwd_odd_silent: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && (direction_ff == DIR_FORWARD) && position_ff[0] && !lastp
      |-> push.count == 2'd0)
      else $error("forward odd sample pushed results before sequence end");

endmodule

>>> rtl/core/lwt53_rsp_queue.sv
// result queue taking up to three results per cycle and releasing one while out_ready is high
module lwt53_rsp_queue #(
   parameter int SAMPLE_BITS = lwt53_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lwt53_pkg::push_type           push,
   input  logic [2:0][SAMPLE_BITS-1:0]   push_value,
   output logic                          space_ok,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [SAMPLE_BITS-1:0]        out_value,
   output lwt53_pkg::rsp_tag_type        out_tag
);
   import lwt53_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS = PTR_BITS + 1;

   logic [SAMPLE_BITS-1:0] value_ff [QUEUE_DEPTH];
   rsp_tag_type            tag_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]    head_ff, head_in;
   logic [PTR_BITS-1:0]    tail_ff, tail_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   pop;

   assign out_valid = (count_ff != '0);
   assign pop = out_valid && out_ready;
   assign out_value = value_ff[head_ff];
   assign out_tag = tag_ff[head_ff];
   assign count_in = count_ff + COUNT_BITS'(push.count) - COUNT_BITS'(pop);
   assign head_in = head_ff + PTR_BITS'(pop);
   assign tail_in = tail_ff + PTR_BITS'(push.count);
   // room for a worst-case burst from the transaction taken this cycle
   assign space_ok = (count_in <= COUNT_BITS'(QUEUE_DEPTH - RESULTS_MAX));

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < RESULTS_MAX; k++) begin
         if (k < int'(push.count)) begin
            value_ff[tail_ff + PTR_BITS'(k)] <= push_value[k];
            tag_ff[tail_ff + PTR_BITS'(k)] <= push.tag[k];
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(QUEUE_DEPTH))
      else $error("result queue overflow");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (count_ff == COUNT_BITS'(1)) && out_ready && (push.count == 2'd0) |=> !out_valid)
      else $error("result queue still valid after its only entry left");

endmodule

>>> dv/tb.sv
// self-checking testbench of the streaming 5/3 lifting wavelet core, forward and inverse
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lwt53_pkg::*;

   localparam int SB = SAMPLE_BITS_DEFAULT;
   localparam int SAMPLE_MAX = (1 << (SB - 1)) - 1;
   localparam int SAMPLE_MIN = -(1 << (SB - 1));
   localparam int RANDOM_ITEMS = 80;
   localparam int LONGEST_SEQ = 65535;
   localparam int LONG_PART = 30;
   localparam int MAX_GAP = 12;
   localparam int MAX_BURST = 24;
   localparam int SETTLE_CYCLES = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS = 30;

   typedef struct {
      logic signed [SB-1:0] value;
      logic [INDEX_BITS-1:0] index;
      logic                  last;
   } lift_out_type;

   logic clock = 1'b0;
   logic reset;

   lwt53_req_if #(.SAMPLE_BITS(SB)) req_ch ();
   lwt53_rsp_if #(.SAMPLE_BITS(SB)) rsp_ch ();
   lwt53_csr_if csr_ch ();

   lifting_wavelet_53_1d_core #(.SAMPLE_BITS(SB)) uut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   always #4 clock = ~clock;

   // predictor state
   direction_type         dir = DIR_FORWARD;
   logic [INDEX_BITS-1:0] seq_len = INDEX_BITS'(SEQ_LENGTH_RESET);
   logic [INDEX_BITS-1:0] pos = '0;
   int                    prev_even = 0;
   int                    prev_odd = 0;
   int                    held_val = 0;
   int                    even_val = 0;

   lift_out_type lift_queue[$];
   int        fail_count = 0;
   int        quiet_cycles = 0;
   int        burst_left = 0;

   task automatic report_mismatch(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
   endtask

   function automatic int clamp_sample(input int v);
      if (v > SAMPLE_MAX) return SAMPLE_MAX;
      if (v < SAMPLE_MIN) return SAMPLE_MIN;
      return v;
   endfunction

   function automatic void note_lift(input int v, input logic [INDEX_BITS-1:0] idx,
                                     input logic last);
      lift_queue.push_back('{value: SB'(v), index: idx, last: last});
   endfunction

   // one lifting step of the predictor for an accepted sample
   task automatic lift_step(input logic signed [SB-1:0] sample);
      int   x, d, dprev, s, e, o, len;
      logic at_end;
      x = sample;
      len = (seq_len < MIN_SEQ_LENGTH) ? MIN_SEQ_LENGTH : int'(seq_len);
      at_end = (pos == len - 1);
      if (dir == DIR_FORWARD) begin
         if (pos == 0) begin
            even_val = x;
         end else if (pos == 1) begin
            held_val = x;
         end else if (!pos[0]) begin
            d = clamp_sample(held_val - ((even_val + x) >>> 1));
            dprev = (pos == 2) ? d : prev_odd;
            s = clamp_sample(even_val + ((dprev + d) >>> 2));
            note_lift(s, pos - INDEX_BITS'(2), 1'b0);
            note_lift(d, pos - INDEX_BITS'(1), 1'b0);
            if (at_end) note_lift(clamp_sample(x + (d >>> 1)), pos, 1'b1);
            even_val = x;
            prev_odd = d;
         end else if (at_end) begin
            d = clamp_sample(x - even_val);
            s = clamp_sample(even_val + ((prev_odd + d) >>> 2));
            note_lift(s, pos - INDEX_BITS'(1), 1'b0);
            note_lift(d, pos, 1'b1);
         end else begin
            held_val = x;
         end
      end else begin
         if (pos == 0) begin
            held_val = x;
         end else if (pos == 1) begin
            e = clamp_sample(held_val - ((x + x) >>> 2));
            note_lift(e, '0, 1'b0);
            prev_even = e;
            prev_odd = x;
         end else if (!pos[0]) begin
            if (at_end) begin
               e = clamp_sample(x - (prev_odd >>> 1));
               o = clamp_sample(prev_odd + ((prev_even + e) >>> 1));
               note_lift(o, pos - INDEX_BITS'(1), 1'b0);
               note_lift(e, pos, 1'b1);
            end else begin
               held_val = x;
            end
         end else begin
            e = clamp_sample(held_val - ((prev_odd + x) >>> 2));
            o = clamp_sample(prev_odd + ((prev_even + e) >>> 1));
            note_lift(o, pos - INDEX_BITS'(2), 1'b0);
            note_lift(e, pos - INDEX_BITS'(1), 1'b0);
            if (at_end) note_lift(clamp_sample(x + e), pos, 1'b1);
            prev_even = e;
            prev_odd = x;
         end
      end
      pos = at_end ? '0 : pos + 1'b1;
   endtask

   task automatic send_sample(input logic signed [SB-1:0] sample);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, MAX_GAP);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, MAX_BURST);
      end
      req_ch.valid <= 1'b1;
      req_ch.sample <= sample;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      lift_step(sample);
      burst_left--;
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      if (idx == CSR_DIRECTION) begin
         dir = direction_type'(data[0]);
         pos = '0;
      end else if (idx == CSR_SEQ_LENGTH) begin
         seq_len = data;
         pos = '0;
      end
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // stop sending, wait for every pending result and let the pipeline empty
   task automatic settle();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (lift_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [SB-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return SB'($urandom());
         4, 5, 6: return SB'(int'($urandom_range(0, 1023)) - 512);
         7: return SB'(SAMPLE_MAX);
         8: return SB'(SAMPLE_MIN);
         default: return SB'(SAMPLE_MAX - int'($urandom_range(0, 15)));
      endcase
   endfunction

   task automatic test_reset_config();
      for (int i = 0; i < SEQ_LENGTH_RESET; i++)
         send_sample(i[0] ? SB'(SAMPLE_MIN) : SB'(SAMPLE_MAX));
      settle();
   endtask

   task automatic test_short_length();
      write_csr(CSR_SEQ_LENGTH, 16'd0);
      send_sample(SB'(SAMPLE_MAX));
      send_sample(SB'(SAMPLE_MIN));
      send_sample(SB'(SAMPLE_MIN));
      settle();
      write_csr(CSR_DIRECTION, 16'(DIR_INVERSE));
      write_csr(CSR_SEQ_LENGTH, 16'd1);
      send_sample(SB'(SAMPLE_MIN));
      send_sample(SB'(SAMPLE_MAX));
      send_sample(SB'(SAMPLE_MIN));
      settle();
   endtask

   task automatic test_inverse_even_length();
      write_csr(CSR_DIRECTION, 16'(DIR_INVERSE));
      write_csr(CSR_SEQ_LENGTH, 16'd4);
      send_sample(SB'(SAMPLE_MAX));
      send_sample(SB'(SAMPLE_MIN));
      send_sample(SB'(-1));
      send_sample(SB'(SAMPLE_MAX));
      settle();
   endtask

   task automatic test_restart_and_spare_write();
      write_csr(CSR_DIRECTION, 16'(DIR_FORWARD));
      write_csr(CSR_SEQ_LENGTH, 16'd3);
      send_sample(SB'(256));
      send_sample(SB'(-256));
      settle();
      // a write to a known register drops the partial sequence
      write_csr(CSR_DIRECTION, 16'(DIR_FORWARD));
      send_sample(SB'(0));
      send_sample(SB'(SAMPLE_MAX));
      send_sample(SB'(1));
      send_sample(SB'(-2));
      settle();
      // a write to an unmapped index leaves the sequence running
      write_csr(CSR_INDEX_BITS'($urandom_range(CSR_SEQ_LENGTH + 1, 255)), 16'($urandom()));
      send_sample(SB'(SAMPLE_MIN));
      send_sample(SB'(3));
      settle();
   endtask

   task automatic test_random_sequences();
      int sent, len, eff, n;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         write_csr(CSR_DIRECTION, 16'($urandom()));
         case ($urandom_range(0, 9))
            0: len = $urandom_range(0, MIN_SEQ_LENGTH - 1);
            1, 2, 3, 4, 5, 6: len = $urandom_range(MIN_SEQ_LENGTH, 10);
            default: len = $urandom_range(11, 40);
         endcase
         write_csr(CSR_SEQ_LENGTH, 16'(len));
         eff = (len < MIN_SEQ_LENGTH) ? MIN_SEQ_LENGTH : len;
         n = eff * $urandom_range(1, 3);
         if ($urandom_range(0, 3) == 0) n += $urandom_range(1, eff - 1);
         if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
         repeat (n) send_sample(pick_sample());
         sent += n;
         settle();
      end
   endtask

   task automatic test_longest_sequence();
      write_csr(CSR_DIRECTION, 16'(DIR_FORWARD));
      write_csr(CSR_SEQ_LENGTH, 16'(LONGEST_SEQ));
      repeat (LONG_PART) send_sample(pick_sample());
      settle();
      write_csr(CSR_DIRECTION, 16'(DIR_INVERSE));
      repeat (LONG_PART) send_sample(pick_sample());
      settle();
   endtask

   initial begin : rsp_stall_pattern
      int mode, left;
      rsp_ch.ready <= 1'b0;
      mode = 0;
      left = 0;
      forever begin
         @(posedge clock);
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(4, 48);
         end else begin
            left--;
         end
         case (mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= 1'($urandom_range(0, 1));
            2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ch.ready <= (left % 5 != 0);
         endcase
      end
   end

   always @(posedge clock) begin : check_rsp
      lift_out_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (lift_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction, index %0d value %0d",
                                      rsp_ch.index, rsp_ch.value));
         end else begin
            want = lift_queue.pop_front();
            if (rsp_ch.value !== want.value)
               report_mismatch($sformatf("index %0d: value %0d, wanted %0d",
                                         want.index, rsp_ch.value, want.value));
            if (rsp_ch.index !== want.index)
               report_mismatch($sformatf("index %0d, wanted %0d", rsp_ch.index, want.index));
            if (rsp_ch.last !== want.last)
               report_mismatch($sformatf("index %0d: last %b, wanted %b",
                                         want.index, rsp_ch.last, want.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.sample <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= '0;
      csr_ch.data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_config();
      test_short_length();
      test_inverse_even_length();
      test_restart_and_spare_write();
      test_random_sequences();
      test_longest_sequence();
      settle();
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
